[hdl/cpn_pkg.sv]
// ----------------------------------------------------------------------------
// cpn_pkg
// shared types, operation codes and fixed-point helpers for the camera pose block
// ----------------------------------------------------------------------------
package cpn_pkg;

    typedef enum logic [2:0] {
        OP_SET_POS   = 3'd0,
        OP_MOVE      = 3'd1,
        OP_STRAFE    = 3'd2,
        OP_FLY       = 3'd3,
        OP_ROT_YAW   = 3'd4,
        OP_ROT_PITCH = 3'd5,
        OP_SET_YAW   = 3'd6,
        OP_SET_PITCH = 3'd7
    } op_t;

    localparam logic [14:0] PITCH_LIMIT_RESET = 15'd8101;
    localparam logic [15:0] QUARTER_TURN      = 16'd16384;
    localparam int          QUEUE_DEPTH       = 2;
    localparam int          QUEUE_AW          = 1;

    // command as it leaves the front end
    typedef struct packed {
        op_t                op;
        logic signed [31:0] distance;
        logic signed [15:0] angle;
        logic               fly_mode;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic [14:0]        limit;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } res_t;

    // back end sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIN_A,
        ST_SIN_B,
        ST_SIN_C,
        ST_SIN_D,
        ST_MUL_A,
        ST_MUL_B,
        ST_POS,
        ST_DONE
    } state_t;

    // rounded product shift: (p + 8192) >>> 14, floor
    function automatic logic signed [47:0] round14(input logic signed [47:0] p);
        logic signed [47:0] s;
        begin
            s = p + 48'sd8192;
            round14 = s >>> 14;
        end
    endfunction

    // saturating add of a 32-bit position and a wide step
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                    input logic signed [47:0] d);
        logic signed [48:0] s;
        begin
            s = 49'(p) + 49'(d);
            if (s > 49'sd2147483647)
                sat_add = 32'sh7FFFFFFF;
            else if (s < -49'sd2147483648)
                sat_add = 32'sh80000000;
            else
                sat_add = s[31:0];
        end
    endfunction

endpackage

[hdl/cpn_if.sv]
// ----------------------------------------------------------------------------
// cpn_cmd_if / cpn_res_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface cpn_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] distance;
    logic signed [15:0] angle;
    logic               fly_mode;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    modport source (output valid, operation, distance, angle, fly_mode,
                    new_x, new_y, new_z, input ready);
    modport sink (input valid, operation, distance, angle, fly_mode,
                  new_x, new_y, new_z, output ready);
    modport monitor (input valid, ready, operation, distance, angle, fly_mode,
                     new_x, new_y, new_z);
endinterface

interface cpn_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    modport source (output valid, out_x, out_y, out_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, out_x, out_y, out_z, dir_x, dir_y, dir_z,
                  output ready);
    modport monitor (input valid, ready, out_x, out_y, out_z, dir_x, dir_y, dir_z);
endinterface

[hdl/cpn_front.sv]
// ----------------------------------------------------------------------------
// cpn_front
// accepts commands, tags them with the current pitch limit and queues them
// ----------------------------------------------------------------------------
module cpn_front (
    input  logic            clk,
    input  logic            rst_n,
    cpn_cmd_if.sink         cmd,
    input  logic [14:0]     limit,
    output logic            q_valid,
    input  logic            q_pop,
    output cpn_pkg::cmd_t   q_head
);

    cpn_pkg::cmd_t                        slot_reg [cpn_pkg::QUEUE_DEPTH];
    logic [cpn_pkg::QUEUE_AW-1:0]         wr_reg, wr_next;
    logic [cpn_pkg::QUEUE_AW-1:0]         rd_reg, rd_next;
    logic [cpn_pkg::QUEUE_AW:0]           cnt_reg, cnt_next;
    logic                                 push;
    cpn_pkg::cmd_t                        in_cmd;

    // classify the incoming transaction
    always_comb
    begin
        in_cmd.op       = cpn_pkg::op_t'(cmd.operation);
        in_cmd.distance = cmd.distance;
        in_cmd.angle    = cmd.angle;
        in_cmd.fly_mode = cmd.fly_mode;
        in_cmd.new_x    = cmd.new_x;
        in_cmd.new_y    = cmd.new_y;
        in_cmd.new_z    = cmd.new_z;
        in_cmd.limit    = limit;
    end

    assign cmd.ready = (cnt_reg != (cpn_pkg::QUEUE_AW+1)'(cpn_pkg::QUEUE_DEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != '0);
    assign q_head    = slot_reg[rd_reg];

    // queue pointers
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = q_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= in_cmd;
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (cpn_pkg::QUEUE_AW+1)'(cpn_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

[hdl/cpn_back.sv]
// ----------------------------------------------------------------------------
// cpn_back
// executes one command at a time: pose update, sine/cosine and products
// ----------------------------------------------------------------------------
module cpn_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  cpn_pkg::cmd_t   q_head,
    cpn_res_if.source       res
);

    cpn_pkg::state_t        st_reg, st_next;
    cpn_pkg::cmd_t          c_reg;
    logic signed [31:0]     px_reg, py_reg, pz_reg;
    logic [15:0]            yaw_reg, pitch_reg;
    // sine unit shared over four angles: cos p, sin p, cos y, sin y (or strafe)
    logic [1:0]             k_reg;
    logic signed [15:0]     trig_reg [4];
    logic signed [15:0]     vx_reg, vz_reg;
    logic signed [47:0]     sx_reg, sy_reg, sz_reg;
    logic                   pre_reg;      // first pass for move or strafe: step direction
    logic                   out_v_reg;
    cpn_pkg::res_t          out_reg;

    // sine pipeline registers
    logic [15:0]            sa;
    logic [1:0]             q_reg;
    logic [14:0]            r_reg;
    logic [14:0]            t2_reg;
    logic [15:0]            mid_reg;
    logic signed [15:0]     s_val;
    logic [29:0]            rr;
    logic [29:0]            t2m;
    logic [14:0]            in_val;
    logic [29:0]            tin;
    logic [30:0]            rm;
    logic [15:0]            smag;

    // angle fed to the sine unit
    always_comb
    begin
        case (k_reg)
            2'd0:    sa = pitch_reg + cpn_pkg::QUARTER_TURN;
            2'd1:    sa = pitch_reg;
            2'd2:    sa = (c_reg.op == cpn_pkg::OP_STRAFE && pre_reg)
                          ? yaw_reg : yaw_reg + cpn_pkg::QUARTER_TURN;
            default: sa = (c_reg.op == cpn_pkg::OP_STRAFE && pre_reg)
                          ? yaw_reg - cpn_pkg::QUARTER_TURN : yaw_reg;
        endcase
    end

    // polynomial pieces
    always_comb
    begin
        rr     = 30'(r_reg) * 30'(r_reg);
        t2m    = 30'(t2_reg) * 30'd1160;
        in_val = 15'd10512 - 15'(t2m[29:14]);
        tin    = 30'(t2_reg) * 30'(in_val);
        rm     = 31'(r_reg) * 31'(mid_reg);
        smag   = (rm[30:14] > 17'd16384) ? 16'd16384 : rm[29:14];
        s_val  = q_reg[1] ? -$signed(smag) : $signed(smag);
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            cpn_pkg::ST_IDLE:  if (q_valid && !out_v_reg) st_next = cpn_pkg::ST_SIN_A;
            cpn_pkg::ST_SIN_A: st_next = cpn_pkg::ST_SIN_B;
            cpn_pkg::ST_SIN_B: st_next = cpn_pkg::ST_SIN_C;
            cpn_pkg::ST_SIN_C: st_next = cpn_pkg::ST_SIN_D;
            cpn_pkg::ST_SIN_D: st_next = (k_reg == 2'd3) ? cpn_pkg::ST_MUL_A
                                                         : cpn_pkg::ST_SIN_A;
            cpn_pkg::ST_MUL_A: st_next = cpn_pkg::ST_MUL_B;
            cpn_pkg::ST_MUL_B: st_next = pre_reg ? cpn_pkg::ST_POS : cpn_pkg::ST_DONE;
            cpn_pkg::ST_POS:   st_next = cpn_pkg::ST_SIN_A;
            cpn_pkg::ST_DONE:  st_next = cpn_pkg::ST_IDLE;
            default:           st_next = cpn_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop = (st_reg == cpn_pkg::ST_IDLE) && q_valid && !out_v_reg;
    end

    assign res.valid = out_v_reg;
    assign res.out_x = out_reg.out_x;
    assign res.out_y = out_reg.out_y;
    assign res.out_z = out_reg.out_z;
    assign res.dir_x = out_reg.dir_x;
    assign res.dir_y = out_reg.dir_y;
    assign res.dir_z = out_reg.dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= cpn_pkg::ST_IDLE;
            out_v_reg <= 1'b0;
            px_reg    <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
            yaw_reg   <= '0;
            pitch_reg <= '0;
            k_reg     <= '0;
            pre_reg   <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (res.valid && res.ready)
                out_v_reg <= 1'b0;
            case (st_reg)
                cpn_pkg::ST_IDLE:
                begin
                    k_reg <= '0;
                    if (q_pop)
                    begin
                        pre_reg <= (q_head.op == cpn_pkg::OP_MOVE)
                                   || (q_head.op == cpn_pkg::OP_STRAFE);
                    end
                end
                cpn_pkg::ST_SIN_D:  k_reg <= k_reg + 2'd1;
                cpn_pkg::ST_POS:
                begin
                    pre_reg <= 1'b0;
                    if (c_reg.op == cpn_pkg::OP_MOVE)
                    begin
                        px_reg <= cpn_pkg::sat_add(px_reg, sx_reg);
                        pz_reg <= cpn_pkg::sat_add(pz_reg, sz_reg);
                        if (c_reg.fly_mode)
                            py_reg <= cpn_pkg::sat_add(py_reg, sy_reg);
                    end
                    else
                    begin
                        px_reg <= cpn_pkg::sat_add(px_reg, sx_reg);
                        pz_reg <= cpn_pkg::sat_add(pz_reg, sz_reg);
                    end
                end
                cpn_pkg::ST_DONE:   out_v_reg <= 1'b1;
                default: ;
            endcase
            // simple pose edits happen on pop
            if (q_pop)
            begin
                case (q_head.op)
                    cpn_pkg::OP_SET_POS:
                    begin
                        px_reg <= q_head.new_x;
                        py_reg <= q_head.new_y;
                        pz_reg <= q_head.new_z;
                    end
                    cpn_pkg::OP_FLY:
                        py_reg <= cpn_pkg::sat_add(py_reg, 48'(q_head.distance));
                    cpn_pkg::OP_ROT_YAW:  yaw_reg <= yaw_reg + q_head.angle;
                    cpn_pkg::OP_ROT_PITCH:
                    begin
                        if (17'($signed(pitch_reg)) + 17'(q_head.angle)
                            > $signed({2'b0, q_head.limit}))
                            pitch_reg <= {1'b0, q_head.limit};
                        else if (17'($signed(pitch_reg)) + 17'(q_head.angle)
                                 < -$signed({2'b0, q_head.limit}))
                            pitch_reg <= -{1'b0, q_head.limit};
                        else
                            pitch_reg <= pitch_reg + q_head.angle;
                    end
                    cpn_pkg::OP_SET_YAW:   yaw_reg <= q_head.angle;
                    cpn_pkg::OP_SET_PITCH: pitch_reg <= q_head.angle;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
            c_reg <= q_head;
        case (st_reg)
            cpn_pkg::ST_SIN_A:
            begin
                q_reg <= sa[15:14];
                r_reg <= sa[14] ? 15'd16384 - 15'(sa[13:0]) : 15'(sa[13:0]);
            end
            cpn_pkg::ST_SIN_B: t2_reg  <= rr[28:14];
            cpn_pkg::ST_SIN_C: mid_reg <= 16'd25736 - 16'(tin[29:14]);
            cpn_pkg::ST_SIN_D: trig_reg[k_reg] <= s_val;
            cpn_pkg::ST_MUL_A:
            begin
                // view vector x and z, or the strafe unit vector
                if (c_reg.op == cpn_pkg::OP_STRAFE && pre_reg)
                begin
                    vx_reg <= trig_reg[2];
                    vz_reg <= trig_reg[3];
                end
                else
                begin
                    vx_reg <= 16'(cpn_pkg::round14(48'(trig_reg[2]) * 48'(trig_reg[0])));
                    vz_reg <= 16'(cpn_pkg::round14(48'(trig_reg[3]) * 48'(trig_reg[0])));
                end
            end
            cpn_pkg::ST_MUL_B:
            begin
                // position steps: distance times direction
                sx_reg <= cpn_pkg::round14(48'(c_reg.distance) * 48'(vx_reg));
                sy_reg <= cpn_pkg::round14(48'(c_reg.distance) * 48'(trig_reg[1]));
                sz_reg <= cpn_pkg::round14(48'(c_reg.distance) * 48'(vz_reg));
                out_reg.out_x <= px_reg;
                out_reg.out_y <= py_reg;
                out_reg.out_z <= pz_reg;
                out_reg.dir_x <= vx_reg;
                out_reg.dir_y <= trig_reg[1];
                out_reg.dir_z <= vz_reg;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == cpn_pkg::ST_IDLE) else $error("pop while busy");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == cpn_pkg::ST_DONE |=> out_v_reg) else $error("result not posted");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !res.ready) |=> $stable(out_reg)) else $error("result changed");
`endif

endmodule

[hdl/camera_pose_navigator.sv]
// ----------------------------------------------------------------------------
// camera_pose_navigator
// first-person camera pose with yaw/pitch, saturating moves and view vector
// ----------------------------------------------------------------------------
// Each command returns one result transaction holding the new Q16.16
// position and the Q1.14 view vector. Once the back end takes a command it
// runs the shared four-step sine unit on it until the result is valid; the
// unit is run for four angles per pass (two passes for move and strafe). The
// back end takes the next command only after the result has been accepted. A
// two-entry queue lets new commands be taken while the back end works or a
// result waits. pitch_limit is to be written through cfg_we/cfg_data only
// while the block is idle; the block itself does not enforce this.
module camera_pose_navigator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [14:0] cfg_data,
    cpn_cmd_if.sink     cmd,
    cpn_res_if.source   res
);

    logic [14:0]    limit_reg;
    logic           q_valid;
    logic           q_pop;
    cpn_pkg::cmd_t  q_head;

    // pitch limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= cpn_pkg::PITCH_LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_data;
    end

    cpn_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .limit   (limit_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_head  (q_head)
    );

    cpn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .res     (res)
    );

endmodule
